// ===== rtl/vcfb_pkg.sv =====
`default_nettype none

package vcfb_pkg;

   // Command codes
   localparam logic [3:0] ACT_FILL   = 4'd0;
   localparam logic [3:0] ACT_SET    = 4'd1;
   localparam logic [3:0] ACT_READ   = 4'd2;
   localparam logic [3:0] ACT_CUBE   = 4'd3;
   localparam logic [3:0] ACT_XZ     = 4'd4;
   localparam logic [3:0] ACT_YZ     = 4'd5;
   localparam logic [3:0] ACT_XY     = 4'd6;
   localparam logic [3:0] ACT_SCROLL = 4'd7;
   localparam logic [3:0] ACT_LETTER = 4'd8;

   // Scroll steps as 4-bit two's complement
   localparam logic [3:0] STEP_UP   = 4'b0001;
   localparam logic [3:0] STEP_DOWN = 4'b1111;

   localparam logic [3:0] EDGE_MAX  = 4'd8;
   localparam int         ROWS      = 64;

   // Glyph indices that carry a pattern
   localparam logic [4:0] GLYPH_A = 5'd0;
   localparam logic [4:0] GLYPH_C = 5'd2;
   localparam logic [4:0] GLYPH_E = 5'd4;
   localparam logic [4:0] GLYPH_H = 5'd7;
   localparam logic [4:0] GLYPH_K = 5'd10;
   localparam logic [4:0] GLYPH_P = 5'd15;
   localparam logic [4:0] GLYPH_S = 5'd18;

   typedef logic [7:0] row_type;

   // One command word as held in the input register
   typedef struct packed {
      logic [3:0] action;
      logic [3:0] axis_x;
      logic [3:0] axis_y;
      logic [3:0] axis_z;
      logic [3:0] edge_length;
      logic [7:0] fill_byte;
      logic [4:0] glyph_index;
   } cmd_type;

   // Letter patterns; byte k (bits 8k+7:8k) goes to the row at z = k
   function automatic logic [63:0] glyph_rows(input logic [4:0] idx);
      logic [63:0] pat;
      unique case (idx)
         GLYPH_A: pat = 64'h183C_6666_7E7E_C2C3;
         GLYPH_C: pat = 64'hFEFF_0703_0307_FFFE;
         GLYPH_E: pat = 64'hFFFF_033F_3F03_FFFF;
         GLYPH_H: pat = 64'hC3C3_C3FF_FFC3_C3C3;
         GLYPH_K: pat = 64'hC363_330F_0F33_63C3;
         GLYPH_P: pat = 64'hFFFF_C3C3_FFFF_0303;
         GLYPH_S: pat = 64'hFFFF_03FF_FFC0_FFFF;
         default: pat = 64'h0;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/voxel_cube_frame_buffer_core.sv =====
// 8x8x8 voxel frame buffer, held as 64 rows of 8 x-bits (row index z*8+y).
// Input channel req_*: one command word per handshake (fill, set, read, solid
// cube, XZ/YZ/XY plane, scroll, letter). Result channel rsp_*: exactly one
// word per command, rsp_voxel_on carrying the addressed voxel for a read and
// 0 otherwise.
// A command is captured in an input register, then the whole image is updated
// in the cycle in which it moves into the result register, so the
// image change and the result appear together. The result word passes
// through the input register and then the result register before rsp_valid
// rises; one command is taken every cycle while the receiver keeps rsp_ready
// high. Updating all 512 voxel flops at once sets that rate.
// When the receiver stalls, the result register holds its word and the input
// register fills; req_ready falls once both are occupied and rises as soon
// as the result word is taken.
// Synchronous reset clears both pipeline valids and darkens the whole cube;
// the first command may be presented in the cycle after reset is released.
`default_nettype none

module voxel_cube_frame_buffer_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [3:0] req_action,
   input  wire logic [3:0] req_axis_x,
   input  wire logic [3:0] req_axis_y,
   input  wire logic [3:0] req_axis_z,
   input  wire logic [3:0] req_edge_length,
   input  wire logic [7:0] req_fill_byte,
   input  wire logic [4:0] req_glyph_index,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_voxel_on
);

   vcfb_pkg::cmd_type cmd_ff;
   logic              cmd_valid_ff;
   logic              rsp_valid_ff;
   logic              rsp_voxel_on_ff;
   logic              advance;

   vcfb_pkg::row_type rows_ff   [vcfb_pkg::ROWS];
   vcfb_pkg::row_type rows_in   [vcfb_pkg::ROWS];
   vcfb_pkg::row_type shift_x   [vcfb_pkg::ROWS];
   vcfb_pkg::row_type shift_y   [vcfb_pkg::ROWS];
   vcfb_pkg::row_type shift_z   [vcfb_pkg::ROWS];

   logic [2:0]  x3, y3, z3;
   logic        x_ok, y_ok, z_ok;
   logic [5:0]  addr;
   logic [3:0]  edge_clip;
   logic [15:0] cube_mask_wide;
   logic [7:0]  cube_mask;
   logic [7:0]  x_bit;
   logic [63:0] glyph;
   logic        read_bit;

   // Pipeline control
   assign advance   = cmd_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !cmd_valid_ff || advance;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_voxel_on = rsp_voxel_on_ff;

   // Decode coordinates of the held command
   assign x3   = cmd_ff.axis_x[2:0];
   assign y3   = cmd_ff.axis_y[2:0];
   assign z3   = cmd_ff.axis_z[2:0];
   assign x_ok = !cmd_ff.axis_x[3];
   assign y_ok = !cmd_ff.axis_y[3];
   assign z_ok = !cmd_ff.axis_z[3];
   assign addr = {z3, y3};
   assign x_bit = 8'd1 << x3;
   assign glyph = vcfb_pkg::glyph_rows(cmd_ff.glyph_index);

   // Cube mask: edge ones shifted up by x, clipped to the row
   assign edge_clip = (cmd_ff.edge_length > vcfb_pkg::EDGE_MAX) ?
                      vcfb_pkg::EDGE_MAX : cmd_ff.edge_length;
   assign cube_mask_wide = ((16'd1 << edge_clip) - 16'd1) << x3;
   assign cube_mask      = cube_mask_wide[7:0];

   assign read_bit = x_ok && y_ok && z_ok && rows_ff[addr][x3];

   // Scroll: x first, then y, then z, zero fill
   always_comb begin
      for (int k = 0; k < vcfb_pkg::ROWS; k++) begin
         if (cmd_ff.axis_x == vcfb_pkg::STEP_UP)
            shift_x[k] = {rows_ff[k][6:0], 1'b0};
         else if (cmd_ff.axis_x == vcfb_pkg::STEP_DOWN)
            shift_x[k] = {1'b0, rows_ff[k][7:1]};
         else
            shift_x[k] = rows_ff[k];
      end
      for (int zi = 0; zi < 8; zi++) begin
         for (int yi = 0; yi < 8; yi++) begin
            if (cmd_ff.axis_y == vcfb_pkg::STEP_UP)
               shift_y[6'(zi * 8 + yi)] = (yi > 0) ? shift_x[6'(zi * 8 + yi - 1)] : 8'h00;
            else if (cmd_ff.axis_y == vcfb_pkg::STEP_DOWN)
               shift_y[6'(zi * 8 + yi)] = (yi < 7) ? shift_x[6'(zi * 8 + yi + 1)] : 8'h00;
            else
               shift_y[6'(zi * 8 + yi)] = shift_x[6'(zi * 8 + yi)];
         end
      end
      for (int zi = 0; zi < 8; zi++) begin
         for (int yi = 0; yi < 8; yi++) begin
            if (cmd_ff.axis_z == vcfb_pkg::STEP_UP)
               shift_z[6'(zi * 8 + yi)] = (zi > 0) ? shift_y[6'((zi - 1) * 8 + yi)] : 8'h00;
            else if (cmd_ff.axis_z == vcfb_pkg::STEP_DOWN)
               shift_z[6'(zi * 8 + yi)] = (zi < 7) ? shift_y[6'((zi + 1) * 8 + yi)] : 8'h00;
            else
               shift_z[6'(zi * 8 + yi)] = shift_y[6'(zi * 8 + yi)];
         end
      end
   end

   // Next image: apply the held command as it moves to the result register
   always_comb begin
      for (int k = 0; k < vcfb_pkg::ROWS; k++)
         rows_in[k] = rows_ff[k];
      if (advance) begin
         unique case (cmd_ff.action)
            vcfb_pkg::ACT_FILL: begin
               for (int k = 0; k < vcfb_pkg::ROWS; k++)
                  rows_in[k] = cmd_ff.fill_byte;
            end
            vcfb_pkg::ACT_SET: begin
               if (x_ok && y_ok && z_ok)
                  rows_in[addr] = rows_ff[addr] | x_bit;
            end
            vcfb_pkg::ACT_CUBE: begin
               if (x_ok && y_ok && z_ok && edge_clip != 4'd0) begin
                  for (int zi = 0; zi < 8; zi++) begin
                     for (int yi = 0; yi < 8; yi++) begin
                        if (4'(zi) >= {1'b0, z3} && (4'(zi) - {1'b0, z3}) < edge_clip &&
                            4'(yi) >= {1'b0, y3} && (4'(yi) - {1'b0, y3}) < edge_clip)
                           rows_in[6'(zi * 8 + yi)] = cube_mask;
                     end
                  end
               end
            end
            vcfb_pkg::ACT_XZ: begin
               if (y_ok)
                  for (int zi = 0; zi < 8; zi++)
                     rows_in[{3'(zi), y3}] = 8'hFF;
            end
            vcfb_pkg::ACT_YZ: begin
               if (x_ok)
                  for (int k = 0; k < vcfb_pkg::ROWS; k++)
                     rows_in[k] = rows_ff[k] | x_bit;
            end
            vcfb_pkg::ACT_XY: begin
               if (z_ok)
                  for (int yi = 0; yi < 8; yi++)
                     rows_in[{z3, 3'(yi)}] = 8'hFF;
            end
            vcfb_pkg::ACT_SCROLL: begin
               for (int k = 0; k < vcfb_pkg::ROWS; k++)
                  rows_in[k] = shift_z[k];
            end
            vcfb_pkg::ACT_LETTER: begin
               if (y_ok)
                  for (int zi = 0; zi < 8; zi++)
                     rows_in[{3'(zi), y3}] = glyph[zi * 8 +: 8];
            end
            default: begin
            end
         endcase
      end
   end

   // Image store; reset darkens the cube
   always_ff @(posedge clock) begin
      for (int k = 0; k < vcfb_pkg::ROWS; k++)
         rows_ff[k] <= reset ? 8'h00 : rows_in[k];
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else if (req_ready) begin
         cmd_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff.action      <= req_action;
         cmd_ff.axis_x      <= req_axis_x;
         cmd_ff.axis_y      <= req_axis_y;
         cmd_ff.axis_z      <= req_axis_z;
         cmd_ff.edge_length <= req_edge_length;
         cmd_ff.fill_byte   <= req_fill_byte;
         cmd_ff.glyph_index <= req_glyph_index;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance)
         rsp_voxel_on_ff <= (cmd_ff.action == vcfb_pkg::ACT_READ) && read_bit;
   end

   // Checks
   a_ready_when_out_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled with the result register empty");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input taken while both stages are held");

   a_fill_applied: assert property (@(posedge clock) disable iff (reset)
      (advance && cmd_ff.action == vcfb_pkg::ACT_FILL) |=>
      (rows_ff[0] == $past(cmd_ff.fill_byte) && rows_ff[63] == $past(cmd_ff.fill_byte)))
      else $error("fill command did not reach the image");

   a_read_result: assert property (@(posedge clock) disable iff (reset)
      (advance && cmd_ff.action == vcfb_pkg::ACT_READ) |=>
      (rsp_valid_ff && rsp_voxel_on_ff == $past(read_bit)))
      else $error("read result does not match the addressed voxel");

endmodule

`default_nettype wire

// ===== tb/voxel_image_checker.sv =====
`timescale 1ns / 100ps

module voxel_image_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [3:0] req_action,
   input  wire logic [3:0] req_axis_x,
   input  wire logic [3:0] req_axis_y,
   input  wire logic [3:0] req_axis_z,
   input  wire logic [3:0] req_edge_length,
   input  wire logic [7:0] req_fill_byte,
   input  wire logic [4:0] req_glyph_index,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic       rsp_voxel_on,
   output int              fault_count,
   output int              words_due,
   output int              reads_checked,
   output int              lit_reads
);

   // Predicted image: row z*8+y, bit x is voxel (x, y, z)
   logic [7:0] image_rows [vcfb_pkg::ROWS];
   logic       voxel_on_due [$];
   logic       read_due [$];

   // Byte k of a letter lands in the row at z = k
   function automatic logic [7:0] letter_byte(input logic [4:0] idx, input int k);
      logic [0:7][7:0] pat;
      case (idx)
         vcfb_pkg::GLYPH_A: pat = {8'hC3, 8'hC2, 8'h7E, 8'h7E, 8'h66, 8'h66, 8'h3C, 8'h18};
         vcfb_pkg::GLYPH_C: pat = {8'hFE, 8'hFF, 8'h07, 8'h03, 8'h03, 8'h07, 8'hFF, 8'hFE};
         vcfb_pkg::GLYPH_E: pat = {8'hFF, 8'hFF, 8'h03, 8'h3F, 8'h3F, 8'h03, 8'hFF, 8'hFF};
         vcfb_pkg::GLYPH_H: pat = {8'hC3, 8'hC3, 8'hC3, 8'hFF, 8'hFF, 8'hC3, 8'hC3, 8'hC3};
         vcfb_pkg::GLYPH_K: pat = {8'hC3, 8'h63, 8'h33, 8'h0F, 8'h0F, 8'h33, 8'h63, 8'hC3};
         vcfb_pkg::GLYPH_P: pat = {8'h03, 8'h03, 8'hFF, 8'hFF, 8'hC3, 8'hC3, 8'hFF, 8'hFF};
         vcfb_pkg::GLYPH_S: pat = {8'hFF, 8'hFF, 8'hC0, 8'hFF, 8'hFF, 8'h03, 8'hFF, 8'hFF};
         default: pat = '0;
      endcase
      return pat[k];
   endfunction

   // Apply one command to the predicted image and return the expected voxel_on
   function automatic logic apply_voxel_command(input vcfb_pkg::cmd_type c);
      int         x, y, z, len, src;
      logic [7:0] mask;
      logic [7:0] moved [vcfb_pkg::ROWS];
      logic       lit;
      lit = 1'b0;
      x = $signed(c.axis_x);
      y = $signed(c.axis_y);
      z = $signed(c.axis_z);
      case (c.action)
         vcfb_pkg::ACT_FILL: begin
            for (int k = 0; k < vcfb_pkg::ROWS; k++) image_rows[k] = c.fill_byte;
         end
         vcfb_pkg::ACT_SET: begin
            if (x >= 0 && y >= 0 && z >= 0) image_rows[z*8+y][x] = 1'b1;
         end
         vcfb_pkg::ACT_READ: begin
            if (x >= 0 && y >= 0 && z >= 0) lit = image_rows[z*8+y][x];
         end
         vcfb_pkg::ACT_CUBE: begin
            // clip rows past 7 and bits past bit 7; edges above 8 act as 8
            if (x >= 0 && y >= 0 && z >= 0 && c.edge_length != 0) begin
               len  = (c.edge_length > vcfb_pkg::EDGE_MAX) ? 8 : int'(c.edge_length);
               mask = 8'(((1 << len) - 1) << x);
               for (int i = 0; i < len; i++)
                  for (int j = 0; j < len; j++)
                     if (z + i < 8 && y + j < 8) image_rows[(z+i)*8 + y + j] = mask;
            end
         end
         vcfb_pkg::ACT_XZ: begin
            if (y >= 0) for (int k = 0; k < 8; k++) image_rows[k*8+y] = 8'hFF;
         end
         vcfb_pkg::ACT_YZ: begin
            if (x >= 0) for (int k = 0; k < vcfb_pkg::ROWS; k++) image_rows[k][x] = 1'b1;
         end
         vcfb_pkg::ACT_XY: begin
            if (z >= 0) for (int k = 0; k < 8; k++) image_rows[z*8+k] = 8'hFF;
         end
         vcfb_pkg::ACT_SCROLL: begin
            // x first, then y, then z; steps other than +1/-1 hold their axis
            for (int k = 0; k < vcfb_pkg::ROWS; k++) begin
               if (x == 1) image_rows[k] = image_rows[k] << 1;
               else if (x == -1) image_rows[k] = image_rows[k] >> 1;
            end
            if (y == 1 || y == -1) begin
               for (int zz = 0; zz < 8; zz++)
                  for (int yy = 0; yy < 8; yy++) begin
                     src = yy - y;
                     moved[zz*8+yy] = (src < 0 || src > 7) ? 8'h00 : image_rows[zz*8+src];
                  end
               image_rows = moved;
            end
            if (z == 1 || z == -1) begin
               for (int zz = 0; zz < 8; zz++)
                  for (int yy = 0; yy < 8; yy++) begin
                     src = zz - z;
                     moved[zz*8+yy] = (src < 0 || src > 7) ? 8'h00 : image_rows[src*8+yy];
                  end
               image_rows = moved;
            end
         end
         vcfb_pkg::ACT_LETTER: begin
            if (y >= 0)
               for (int k = 0; k < 8; k++) image_rows[k*8+y] = letter_byte(c.glyph_index, k);
         end
         default: ;
      endcase
      return lit;
   endfunction

   // Compare result words first: a word taken at this edge belongs to an older command
   always @(posedge clock) begin : watch
      vcfb_pkg::cmd_type cmd;
      logic    want, was_read;
      if (reset) begin
         for (int k = 0; k < vcfb_pkg::ROWS; k++) image_rows[k] = 8'h00;
         voxel_on_due.delete();
         read_due.delete();
         fault_count   = 0;
         reads_checked = 0;
         lit_reads     = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (voxel_on_due.size() == 0) begin
               fault_count++;
               $display("%t: result word with nothing expected, got voxel_on %0b",
                        $time, rsp_voxel_on);
            end else begin
               want     = voxel_on_due.pop_front();
               was_read = read_due.pop_front();
               if (was_read) begin
                  reads_checked++;
                  if (want) lit_reads++;
               end
               if (rsp_voxel_on !== want) begin
                  fault_count++;
                  $display("%t: voxel_on mismatch, expected %0b, got %0b",
                           $time, want, rsp_voxel_on);
               end
            end
         end
         if (req_valid && req_ready) begin
            cmd.action      = req_action;
            cmd.axis_x      = req_axis_x;
            cmd.axis_y      = req_axis_y;
            cmd.axis_z      = req_axis_z;
            cmd.edge_length = req_edge_length;
            cmd.fill_byte   = req_fill_byte;
            cmd.glyph_index = req_glyph_index;
            voxel_on_due.push_back(apply_voxel_command(cmd));
            read_due.push_back(cmd.action == vcfb_pkg::ACT_READ);
         end
      end
      words_due = voxel_on_due.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid;
   logic       req_ready;
   logic [3:0] req_action;
   logic [3:0] req_axis_x;
   logic [3:0] req_axis_y;
   logic [3:0] req_axis_z;
   logic [3:0] req_edge_length;
   logic [7:0] req_fill_byte;
   logic [4:0] req_glyph_index;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_voxel_on;

   int fault_count, words_due, reads_checked, lit_reads;
   int idle_pct  = 0;
   int stall_pct = 0;
   int sent      = 0;

   voxel_cube_frame_buffer_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_axis_x      (req_axis_x),
      .req_axis_y      (req_axis_y),
      .req_axis_z      (req_axis_z),
      .req_edge_length (req_edge_length),
      .req_fill_byte   (req_fill_byte),
      .req_glyph_index (req_glyph_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_voxel_on    (rsp_voxel_on)
   );

   voxel_image_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_axis_x      (req_axis_x),
      .req_axis_y      (req_axis_y),
      .req_axis_z      (req_axis_z),
      .req_edge_length (req_edge_length),
      .req_fill_byte   (req_fill_byte),
      .req_glyph_index (req_glyph_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_voxel_on    (rsp_voxel_on),
      .fault_count     (fault_count),
      .words_due       (words_due),
      .reads_checked   (reads_checked),
      .lit_reads       (lit_reads)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: stall at random for the current phase
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic vcfb_pkg::cmd_type make_cmd(input logic [3:0] act, input logic [3:0] x,
                                        input logic [3:0] y, input logic [3:0] z,
                                        input logic [3:0] len, input logic [7:0] fill,
                                        input logic [4:0] glyph);
      vcfb_pkg::cmd_type c;
      c.action      = act;
      c.axis_x      = x;
      c.axis_y      = y;
      c.axis_z      = z;
      c.edge_length = len;
      c.fill_byte   = fill;
      c.glyph_index = glyph;
      return c;
   endfunction

   // Mostly in range, now and then any 4-bit value (negatives included)
   function automatic logic [3:0] pick_coord();
      return ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(7));
   endfunction

   function automatic logic [3:0] pick_step();
      case ($urandom_range(9))
         0:       return 4'($urandom_range(15));
         1, 2, 3: return vcfb_pkg::STEP_UP;
         4, 5, 6: return vcfb_pkg::STEP_DOWN;
         default: return 4'd0;
      endcase
   endfunction

   // Reads dominate so the image is watched closely; the rest keep it changing
   function automatic vcfb_pkg::cmd_type random_cmd();
      vcfb_pkg::cmd_type c;
      int      r;
      r = $urandom_range(99);
      c = make_cmd(vcfb_pkg::ACT_READ, pick_coord(), pick_coord(), pick_coord(),
                   4'($urandom_range(1, 8)), 8'($urandom), 5'($urandom));
      if (r < 35)      c.action = vcfb_pkg::ACT_READ;
      else if (r < 50) c.action = vcfb_pkg::ACT_SET;
      else if (r < 57) c.action = vcfb_pkg::ACT_FILL;
      else if (r < 64) c.action = vcfb_pkg::ACT_CUBE;
      else if (r < 68) c.action = vcfb_pkg::ACT_XZ;
      else if (r < 72) c.action = vcfb_pkg::ACT_YZ;
      else if (r < 76) c.action = vcfb_pkg::ACT_XY;
      else if (r < 86) c.action = vcfb_pkg::ACT_SCROLL;
      else if (r < 95) c.action = vcfb_pkg::ACT_LETTER;
      else             c.action = 4'($urandom_range(9, 15));
      if (c.action == vcfb_pkg::ACT_SCROLL) begin
         c.axis_x = pick_step();
         c.axis_y = pick_step();
         c.axis_z = pick_step();
      end
      if ($urandom_range(4) == 0) c.edge_length = 4'($urandom_range(15));
      case ($urandom_range(9))
         0: c.glyph_index = vcfb_pkg::GLYPH_A;
         1: c.glyph_index = vcfb_pkg::GLYPH_C;
         2: c.glyph_index = vcfb_pkg::GLYPH_E;
         3: c.glyph_index = vcfb_pkg::GLYPH_H;
         4: c.glyph_index = vcfb_pkg::GLYPH_K;
         5: c.glyph_index = vcfb_pkg::GLYPH_P;
         6: c.glyph_index = vcfb_pkg::GLYPH_S;
         default: ;
      endcase
      return c;
   endfunction

   // Idle for the phase, present the word, hold it until taken
   task automatic send_cmd(input vcfb_pkg::cmd_type c);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= c.action;
      req_axis_x      <= c.axis_x;
      req_axis_y      <= c.axis_y;
      req_axis_z      <= c.axis_z;
      req_edge_length <= c.edge_length;
      req_fill_byte   <= c.fill_byte;
      req_glyph_index <= c.glyph_index;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic send_random(input int count, input int idle, input int stall);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (count) send_cmd(random_cmd());
   endtask

   // Run limit
   initial begin
      #5_000_000;
      $display("voxel_cube_frame_buffer_core test failed");
      $finish;
   end

   initial begin
      req_valid       <= 1'b0;
      req_action      <= vcfb_pkg::ACT_FILL;
      req_axis_x      <= 4'd0;
      req_axis_y      <= 4'd0;
      req_axis_z      <= 4'd0;
      req_edge_length <= 4'd0;
      req_fill_byte   <= 8'd0;
      req_glyph_index <= 5'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: dark cube, fill, bounds, clipping, planes, letters, scroll, unused codes
      send_cmd(make_cmd(vcfb_pkg::ACT_READ,   4'd0, 4'd0, 4'd0, 4'd0,  8'h00, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_FILL,   4'd0, 4'd0, 4'd0, 4'd0,  8'hA5, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_READ,   4'd0, 4'd7, 4'd7, 4'd0,  8'h00, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_READ,   4'd1, 4'd0, 4'd0, 4'd0,  8'h00, 5'd0));
      send_cmd(make_cmd(4'd9,                 4'd3, 4'd3, 4'd3, 4'd8,  8'hFF, 5'd31));
      send_cmd(make_cmd(vcfb_pkg::ACT_SET,    4'hF, 4'd0, 4'd0, 4'd0,  8'h00, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_CUBE,   4'd6, 4'd6, 4'd6, 4'd8,  8'h00, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_READ,   4'd7, 4'd7, 4'd7, 4'd0,  8'h00, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_READ,   4'd7, 4'd7, 4'd7, 4'd0,  8'h00, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_READ,   4'h8, 4'd7, 4'd7, 4'd0,  8'h00, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_CUBE,   4'd0, 4'd0, 4'd0, 4'hF,  8'h00, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_CUBE,   4'hF, 4'd0, 4'd0, 4'd3,  8'h00, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_FILL,   4'd0, 4'd0, 4'd0, 4'd0,  8'h00, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_XZ,     4'd0, 4'd7, 4'd0, 4'd0,  8'h00, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_YZ,     4'd0, 4'd0, 4'd0, 4'd0,  8'h00, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_XY,     4'd0, 4'd0, 4'hF, 4'd0,  8'h00, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_LETTER, 4'd0, 4'd2, 4'd0, 4'd0,  8'h00,
                        vcfb_pkg::GLYPH_A));
      send_cmd(make_cmd(vcfb_pkg::ACT_LETTER, 4'd0, 4'd3, 4'd0, 4'd0,  8'h00, 5'd31));
      send_cmd(make_cmd(vcfb_pkg::ACT_READ,   4'd1, 4'd2, 4'd1, 4'd0,  8'h00, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_SCROLL, vcfb_pkg::STEP_UP, vcfb_pkg::STEP_UP,
                        vcfb_pkg::STEP_UP, 4'd0, 8'h00, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_READ,   4'd2, 4'd3, 4'd2, 4'd0,  8'h00, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_SCROLL, vcfb_pkg::STEP_DOWN, vcfb_pkg::STEP_DOWN,
                        vcfb_pkg::STEP_DOWN, 4'd0, 8'h00, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_SCROLL, 4'd7, 4'h8, 4'd2, 4'd0,  8'h00, 5'd0));
      send_cmd(make_cmd(vcfb_pkg::ACT_READ,   4'd1, 4'd2, 4'd1, 4'd0,  8'h00, 5'd0));
      send_cmd(make_cmd(4'd15,                4'd7, 4'd7, 4'd7, 4'd15, 8'h00, 5'd0));

      // random: free flow, sender gaps, receiver stalls, then both
      send_random(425, 0, 0);
      send_random(425, 75, 0);
      send_random(425, 0, 75);
      send_random(425, 20, 20);
      req_valid <= 1'b0;

      // drain, then leave room for any stray word
      while (words_due != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      $display("%0d commands sent over four handshake phases", sent);
      $display("%0d voxel reads checked, %0d found lit", reads_checked, lit_reads);
      if (fault_count == 0) begin
         $display("voxel_cube_frame_buffer_core test passed");
      end else begin
         $display("voxel_cube_frame_buffer_core test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/vcfb_pkg.sv
rtl/voxel_cube_frame_buffer_core.sv
tb/voxel_image_checker.sv
tb/tb_top.sv
